@@ sv/ttg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_pkg
// Shared constants, types and helper functions of the tensor take unit.
// ----------------------------------------------------------------------------
package ttg_pkg;

    localparam int SOURCE_DEPTH = 4096;
    localparam int INDEX_DEPTH  = 1024;
    localparam int MAX_RANK     = 6;
    localparam int EXTENT_BITS  = 10;

    localparam int SHAPE_W = MAX_RANK * EXTENT_BITS;
    localparam int SRC_AW  = $clog2(SOURCE_DEPTH);
    localparam int IDX_AW  = $clog2(INDEX_DEPTH);
    localparam int POS_W   = 20;
    localparam int ADDR_W  = 12;
    localparam int WORD_W  = 32;
    localparam int RANK_W  = 3;
    localparam int COUNT_W = 21;
    localparam int CFG_W   = 60;
    localparam int ACC_W   = 41;
    localparam int PROD_W  = ACC_W + EXTENT_BITS;
    localparam int SUM_W   = PROD_W + 1;

    localparam logic [ACC_W-1:0]   ADDR_CAP    = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [SHAPE_W-1:0] SHAPE_RESET =
        {MAX_RANK{EXTENT_BITS'(1)}};

    // Signed dimension counter; loops run below zero on the source side.
    typedef logic signed [5:0] dim_t;

    typedef enum logic [1:0] {
        CMD_LOAD_SOURCE = 2'd0,
        CMD_LOAD_INDEX  = 2'd1,
        CMD_GATHER      = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_POS_RANGE  = 2'd1,
        STATUS_INDEX_OVF  = 2'd2,
        STATUS_SOURCE_OVF = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_SOURCE_SHAPE = 3'd0,
        REG_OUTPUT_SHAPE = 3'd1,
        REG_INDEX_SHAPE  = 3'd2,
        REG_SOURCE_RANK  = 3'd3,
        REG_OUTPUT_RANK  = 3'd4,
        REG_INDEX_RANK   = 3'd5,
        REG_GATHER_AXIS  = 3'd6,
        REG_OUTPUT_COUNT = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WRITE,
        OP_CAPTURE,
        OP_DIV_START,
        OP_DIV_WAIT,
        OP_MUL,
        OP_ACC,
        OP_IDX_READ,
        OP_SRC_READ,
        OP_OUT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_P1_MUL,
        S_P1_ADD,
        S_CHK1,
        S_P2_MUL,
        S_P2_ADD,
        S_CLAMP_MUL,
        S_CLAMP_ADD,
        S_P3_MUL,
        S_P3_ADD,
        S_CHK2,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [SHAPE_W-1:0] source_shape;
        logic [SHAPE_W-1:0] output_shape;
        logic [SHAPE_W-1:0] index_shape;
        logic [RANK_W-1:0]  xr;
        logic [RANK_W-1:0]  yr;
        logic [RANK_W-1:0]  ir;
        logic [RANK_W-1:0]  axis;
        logic [COUNT_W-1:0] output_count;
    } cfg_t;

    typedef struct packed {
        dp_op_t  op;
        dim_t    j;
        dim_t    k;
        logic    clamp_sel;
        logic    index_sel;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic pos_oob;
        logic acc_ge_index;
        logic acc_ge_source;
        logic out_free;
    } dp_stat_t;

    function automatic logic [RANK_W-1:0] sat_rank(input logic [RANK_W-1:0] r);
        if (r > RANK_W'(MAX_RANK)) begin
            return RANK_W'(MAX_RANK);
        end
        return r;
    endfunction

    // Extent of dimension dim of a tensor of the given rank; dimensions that
    // fall outside the packed slots read as one.
    function automatic logic [EXTENT_BITS-1:0] extent_at(
        input logic [SHAPE_W-1:0] shape,
        input logic [RANK_W-1:0]  rank,
        input dim_t               dim
    );
        logic signed [7:0] slot;
        slot = 8'(dim) + 8'sd6 - $signed({5'b0, rank});
        if (slot < 8'sd0 || slot >= 8'(MAX_RANK)) begin
            return EXTENT_BITS'(1);
        end
        return shape[EXTENT_BITS*int'(slot[2:0]) +: EXTENT_BITS];
    endfunction

    function automatic logic [ACC_W-1:0] sat_addr(input logic [SUM_W-1:0] v);
        if (v > SUM_W'(ADDR_CAP)) begin
            return ADDR_CAP;
        end
        return v[ACC_W-1:0];
    endfunction

endpackage

@@ sv/ttg_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_div
// Restoring divider, one quotient bit per cycle, position by extent.
// ----------------------------------------------------------------------------
module ttg_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [ttg_pkg::POS_W-1:0]       dividend,
    input  logic [ttg_pkg::EXTENT_BITS-1:0] divisor,
    output logic                            done,
    output logic [ttg_pkg::POS_W-1:0]       quotient,
    output logic [ttg_pkg::EXTENT_BITS-1:0] remainder
);
    import ttg_pkg::*;

    localparam int CNT_W = $clog2(POS_W);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [POS_W-1:0]       quo_reg, quo_next;
    logic [EXTENT_BITS-1:0] rem_reg, rem_next;
    logic [EXTENT_BITS-1:0] div_reg, div_next;
    logic [EXTENT_BITS:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[POS_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = EXTENT_BITS'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[POS_W-2:0], 1'b1};
            end else begin
                rem_next = trial[EXTENT_BITS-1:0];
                quo_next = {quo_reg[POS_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(POS_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ sv/ttg_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_dpath
// Stores, coordinate registers, address accumulator and result register.
// ----------------------------------------------------------------------------
module ttg_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ttg_pkg::cfg_t                 cfg,
    input  ttg_pkg::dp_cmd_t              cmd,
    output ttg_pkg::dp_stat_t             stat,
    input  logic [1:0]                    s_command,
    input  logic [ttg_pkg::ADDR_W-1:0]    s_load_address,
    input  logic signed [ttg_pkg::WORD_W-1:0] s_load_value,
    input  logic [ttg_pkg::POS_W-1:0]     s_position,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [ttg_pkg::WORD_W-1:0] m_value,
    output logic [1:0]                    m_status
);
    import ttg_pkg::*;

    logic [WORD_W-1:0] source_store [SOURCE_DEPTH];
    logic [WORD_W-1:0] index_store  [INDEX_DEPTH];

    logic [EXTENT_BITS-1:0] col_reg [MAX_RANK];
    logic [POS_W-1:0]       o_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [ACC_W-1:0]       stride_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]      sprod_reg;
    logic [WORD_W-1:0]      iw_reg;
    logic [WORD_W-1:0]      src_reg;
    logic                   m_valid_reg;
    logic [WORD_W-1:0]      m_value_reg;
    logic [1:0]             m_status_reg;

    logic [EXTENT_BITS-1:0] out_ext;
    logic [EXTENT_BITS-1:0] div_ext;
    logic                   div_done;
    logic [POS_W-1:0]       div_quo;
    logic [EXTENT_BITS-1:0] div_rem;
    logic [EXTENT_BITS-1:0] src_ext;
    logic [EXTENT_BITS-1:0] mul_ext;
    logic [EXTENT_BITS-1:0] clamp_lim;
    logic [EXTENT_BITS-1:0] clamp_val;
    logic [EXTENT_BITS-1:0] mul_a;
    logic [SUM_W-1:0]       acc_sum;

    // Output extent of dimension j; a zero extent divides as one.
    assign out_ext = extent_at(cfg.output_shape, cfg.yr, cmd.j);
    assign div_ext = (out_ext == '0) ? EXTENT_BITS'(1) : out_ext;

    ttg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.op == OP_DIV_START),
        .dividend  (o_reg),
        .divisor   (div_ext),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Clip the fetched index into [0, extent - 1].
    always_comb begin
        src_ext   = extent_at(cfg.source_shape, cfg.xr, cmd.k);
        clamp_lim = (src_ext == '0) ? '0 : src_ext - EXTENT_BITS'(1);
        if (iw_reg[WORD_W-1]) begin
            clamp_val = '0;
        end else if (iw_reg > WORD_W'(clamp_lim)) begin
            clamp_val = clamp_lim;
        end else begin
            clamp_val = iw_reg[EXTENT_BITS-1:0];
        end
        mul_ext = cmd.index_sel ? extent_at(cfg.index_shape, cfg.ir, cmd.k) : src_ext;
        mul_a   = cmd.clamp_sel ? clamp_val : col_reg[cmd.j[2:0]];
        acc_sum = SUM_W'(acc_reg) + SUM_W'(prod_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_WRITE) begin
            if (s_command == CMD_LOAD_SOURCE &&
                32'(s_load_address) < SOURCE_DEPTH) begin
                source_store[s_load_address[SRC_AW-1:0]] <= s_load_value;
            end
            if (s_command == CMD_LOAD_INDEX &&
                32'(s_load_address) < INDEX_DEPTH) begin
                index_store[s_load_address[IDX_AW-1:0]] <= s_load_value;
            end
        end
        if (cmd.op == OP_IDX_READ) begin
            iw_reg <= index_store[acc_reg[IDX_AW-1:0]];
        end
        if (cmd.op == OP_SRC_READ) begin
            src_reg <= source_store[acc_reg[SRC_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_CAPTURE: begin
                o_reg      <= s_position;
                acc_reg    <= '0;
                stride_reg <= ACC_W'(1);
            end
            OP_DIV_WAIT: begin
                if (div_done) begin
                    col_reg[cmd.j[2:0]] <= div_rem;
                    o_reg               <= div_quo;
                end
            end
            OP_MUL: begin
                prod_reg  <= PROD_W'(mul_a) * PROD_W'(stride_reg);
                sprod_reg <= PROD_W'(stride_reg) * PROD_W'(mul_ext);
            end
            OP_ACC: begin
                acc_reg    <= sat_addr(acc_sum);
                stride_reg <= sat_addr(SUM_W'(sprod_reg));
            end
            OP_IDX_READ: begin
                acc_reg    <= '0;
                stride_reg <= ACC_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_OUT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.op == OP_OUT) begin
            m_status_reg <= cmd.status;
            m_value_reg  <= (cmd.status == STATUS_OK) ? src_reg : '0;
        end
    end

    assign stat.div_done      = div_done;
    assign stat.pos_oob       = COUNT_W'(s_position) >= cfg.output_count;
    assign stat.acc_ge_index  = acc_reg >= ACC_W'(INDEX_DEPTH);
    assign stat.acc_ge_source = acc_reg >= ACC_W'(SOURCE_DEPTH);
    assign stat.out_free      = !m_valid_reg || m_ready;

    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

endmodule

@@ sv/ttg_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_ctrl
// Sequencer: coordinate split, index address, source address, result.
// ----------------------------------------------------------------------------
module ttg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  ttg_pkg::cfg_t     cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_command,
    output ttg_pkg::dp_cmd_t  cmd,
    input  ttg_pkg::dp_stat_t stat
);
    import ttg_pkg::*;

    state_t  state_reg, state_next;
    dim_t    j_reg, j_next;
    dim_t    k_reg, k_next;
    status_t status_reg, status_next;

    dim_t yr_m1;
    dim_t xr_m1;
    dim_t ir_m1;
    dim_t axis_d;
    dim_t span_end;

    assign yr_m1    = dim_t'({3'b0, cfg.yr}) - 6'sd1;
    assign xr_m1    = dim_t'({3'b0, cfg.xr}) - 6'sd1;
    assign ir_m1    = dim_t'({3'b0, cfg.ir}) - 6'sd1;
    assign axis_d   = dim_t'({3'b0, cfg.axis});
    assign span_end = axis_d + dim_t'({3'b0, cfg.ir});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            j_reg      <= '0;
            k_reg      <= '0;
            status_reg <= STATUS_OK;
        end else begin
            state_reg  <= state_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            status_reg <= status_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        status_next   = status_reg;
        s_ready       = 1'b0;
        cmd.op        = OP_NONE;
        cmd.j         = j_reg;
        cmd.k         = k_reg;
        cmd.clamp_sel = 1'b0;
        cmd.index_sel = 1'b0;
        cmd.status    = status_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_command == CMD_GATHER) begin
                        if (stat.pos_oob) begin
                            status_next = STATUS_POS_RANGE;
                            state_next  = S_RESULT;
                        end else begin
                            cmd.op     = OP_CAPTURE;
                            j_next     = yr_m1;
                            state_next = S_DIV_START;
                        end
                    end else begin
                        cmd.op = OP_WRITE;
                    end
                end
            end
            S_DIV_START: begin
                if (j_reg < 6'sd0) begin
                    j_next     = yr_m1;
                    k_next     = ir_m1;
                    state_next = S_P1_MUL;
                end else begin
                    cmd.op     = OP_DIV_START;
                    state_next = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                cmd.op = OP_DIV_WAIT;
                if (stat.div_done) begin
                    j_next     = j_reg - 6'sd1;
                    state_next = S_DIV_START;
                end
            end
            S_P1_MUL: begin
                if (j_reg < axis_d) begin
                    state_next = S_CHK1;
                end else if (j_reg < span_end) begin
                    cmd.op        = OP_MUL;
                    cmd.index_sel = 1'b1;
                    state_next    = S_P1_ADD;
                end else begin
                    j_next = j_reg - 6'sd1;
                end
            end
            S_P1_ADD: begin
                cmd.op     = OP_ACC;
                j_next     = j_reg - 6'sd1;
                k_next     = k_reg - 6'sd1;
                state_next = S_P1_MUL;
            end
            S_CHK1: begin
                if (stat.acc_ge_index) begin
                    status_next = STATUS_INDEX_OVF;
                    state_next  = S_RESULT;
                end else begin
                    cmd.op     = OP_IDX_READ;
                    j_next     = yr_m1;
                    k_next     = xr_m1;
                    state_next = S_P2_MUL;
                end
            end
            S_P2_MUL: begin
                if (j_reg < span_end) begin
                    state_next = S_CLAMP_MUL;
                end else begin
                    cmd.op     = OP_MUL;
                    state_next = S_P2_ADD;
                end
            end
            S_P2_ADD: begin
                cmd.op     = OP_ACC;
                j_next     = j_reg - 6'sd1;
                k_next     = k_reg - 6'sd1;
                state_next = S_P2_MUL;
            end
            S_CLAMP_MUL: begin
                cmd.op        = OP_MUL;
                cmd.clamp_sel = 1'b1;
                state_next    = S_CLAMP_ADD;
            end
            S_CLAMP_ADD: begin
                cmd.op     = OP_ACC;
                j_next     = yr_m1;
                k_next     = k_reg - 6'sd1;
                state_next = S_P3_MUL;
            end
            S_P3_MUL: begin
                if (j_reg < 6'sd0 || k_reg < 6'sd0) begin
                    state_next = S_CHK2;
                end else if (j_reg < axis_d) begin
                    cmd.op     = OP_MUL;
                    state_next = S_P3_ADD;
                end else begin
                    j_next = j_reg - 6'sd1;
                end
            end
            S_P3_ADD: begin
                cmd.op     = OP_ACC;
                j_next     = j_reg - 6'sd1;
                k_next     = k_reg - 6'sd1;
                state_next = S_P3_MUL;
            end
            S_CHK2: begin
                if (stat.acc_ge_source) begin
                    status_next = STATUS_SOURCE_OVF;
                end else begin
                    cmd.op      = OP_SRC_READ;
                    status_next = STATUS_OK;
                end
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/tensor_take_gather_unit.sv @@
`timescale 1ns / 1ps
// A load is written while the unit is idle. A gather divides the position
// by each output extent (one quotient bit per cycle on the shared divider),
// builds each address term by multiply and accumulate, then reads the stores.
// Throughput: one gather at a time, set by the serial divider and the
// multiply-accumulate address unit. Reset is synchronous and active low; it
// restores the configuration defaults and empties the result register.
// ----------------------------------------------------------------------------
// tensor_take_gather_unit
// Gather with clip mode along one axis of a tensor of up to six dimensions.
// ----------------------------------------------------------------------------
module tensor_take_gather_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [ttg_pkg::CFG_W-1:0]         cfg_data,
    // Command channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_command,
    input  logic [ttg_pkg::ADDR_W-1:0]        s_load_address,
    input  logic signed [ttg_pkg::WORD_W-1:0] s_load_value,
    input  logic [ttg_pkg::POS_W-1:0]         s_position,
    // Result channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [ttg_pkg::WORD_W-1:0] m_value,
    output logic [1:0]                        m_status
);
    import ttg_pkg::*;

    // The configuration registers. A configuration transaction lands in the
    // register named by its index. Writes must be issued only while idle; the
    // block does not enforce it, and the port is always ready.
    logic [SHAPE_W-1:0] source_shape_reg;
    logic [SHAPE_W-1:0] output_shape_reg;
    logic [SHAPE_W-1:0] index_shape_reg;
    logic [RANK_W-1:0]  source_rank_reg;
    logic [RANK_W-1:0]  output_rank_reg;
    logic [RANK_W-1:0]  index_rank_reg;
    logic [RANK_W-1:0]  gather_axis_reg;
    logic [COUNT_W-1:0] output_count_reg;

    cfg_t      cfg;
    dp_cmd_t   cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_shape_reg <= SHAPE_RESET;
            output_shape_reg <= SHAPE_RESET;
            index_shape_reg  <= SHAPE_RESET;
            source_rank_reg  <= RANK_W'(1);
            output_rank_reg  <= RANK_W'(1);
            index_rank_reg   <= '0;
            gather_axis_reg  <= '0;
            output_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_SOURCE_SHAPE: source_shape_reg <= cfg_data[SHAPE_W-1:0];
                REG_OUTPUT_SHAPE: output_shape_reg <= cfg_data[SHAPE_W-1:0];
                REG_INDEX_SHAPE:  index_shape_reg  <= cfg_data[SHAPE_W-1:0];
                REG_SOURCE_RANK:  source_rank_reg  <= cfg_data[RANK_W-1:0];
                REG_OUTPUT_RANK:  output_rank_reg  <= cfg_data[RANK_W-1:0];
                REG_INDEX_RANK:   index_rank_reg   <= cfg_data[RANK_W-1:0];
                REG_GATHER_AXIS:  gather_axis_reg  <= cfg_data[RANK_W-1:0];
                REG_OUTPUT_COUNT: output_count_reg <= cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Ranks above the slot count behave as the full rank.
    assign cfg.source_shape = source_shape_reg;
    assign cfg.output_shape = output_shape_reg;
    assign cfg.index_shape  = index_shape_reg;
    assign cfg.xr           = sat_rank(source_rank_reg);
    assign cfg.yr           = sat_rank(output_rank_reg);
    assign cfg.ir           = sat_rank(index_rank_reg);
    assign cfg.axis         = gather_axis_reg;
    assign cfg.output_count = output_count_reg;

    // The controller walks the output coordinates, then the index address,
    // then the source address; the datapath holds all values and stores.
    ttg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .cmd       (cmd),
        .stat      (stat)
    );

    ttg_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .stat           (stat),
        .s_command      (s_command),
        .s_load_address (s_load_address),
        .s_load_value   (s_load_value),
        .s_position     (s_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value        (m_value),
        .m_status       (m_status)
    );

endmodule

@@ tb/ttg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttg_checker
// Watches the configuration, command and result channels of the take unit,
// predicts every gathered word and status, and counts mismatches.
// ----------------------------------------------------------------------------
module ttg_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [ttg_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [1:0]                        s_command,
    input  logic [ttg_pkg::ADDR_W-1:0]        s_load_address,
    input  logic signed [ttg_pkg::WORD_W-1:0] s_load_value,
    input  logic [ttg_pkg::POS_W-1:0]         s_position,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [ttg_pkg::WORD_W-1:0] m_value,
    input  logic [1:0]                        m_status,
    output int                                pending,
    output int                                mismatches
);
    import ttg_pkg::*;

    typedef struct {
        logic [WORD_W-1:0] value;
        status_t           status;
    } gather_result_t;

    localparam longint unsigned CAP = 64'd1 << 40;

    logic [SHAPE_W-1:0] src_shape, out_shape, idx_shape;
    logic [2:0]         src_rank, out_rank, idx_rank, axis_reg;
    logic [COUNT_W-1:0] out_count;
    logic [WORD_W-1:0]  src_mem [SOURCE_DEPTH];
    logic [WORD_W-1:0]  idx_mem [INDEX_DEPTH];
    gather_result_t     expected_q [$];

    function automatic longint unsigned dim_extent(logic [SHAPE_W-1:0] shape, int rank,
                                                   int dim);
        int slot;
        slot = dim + MAX_RANK - rank;
        if (slot < 0 || slot >= MAX_RANK) begin
            return 1;
        end
        return shape[EXTENT_BITS*slot +: EXTENT_BITS];
    endfunction

    function automatic longint unsigned clip(longint unsigned v);
        return (v > CAP) ? CAP : v;
    endfunction

    function automatic int rank_of(logic [2:0] r);
        return (r > MAX_RANK) ? MAX_RANK : int'(r);
    endfunction

    function automatic longint unsigned out_ext(int yr, int dim);
        longint unsigned e;
        e = dim_extent(out_shape, yr, dim);
        return (e == 0) ? 1 : e;
    endfunction

    function automatic gather_result_t gather_word(logic [POS_W-1:0] pos);
        gather_result_t  r;
        int              yr, ir, xr, ax, j, k;
        longint unsigned rest, c, e, iaddr, istride, saddr, sstride, lim, sel;
        logic [WORD_W-1:0] iw;
        r.value = '0;
        if (pos >= out_count) begin
            r.status = STATUS_POS_RANGE;
            return r;
        end
        yr = rank_of(out_rank);
        ir = rank_of(idx_rank);
        xr = rank_of(src_rank);
        ax = int'(axis_reg);
        // Index address from the output coordinates inside the index span.
        rest = pos; iaddr = 0; istride = 1; k = ir - 1;
        for (j = yr - 1; j >= ax; j--) begin
            e = out_ext(yr, j);
            c = rest % e;
            rest = rest / e;
            if (j < ax + ir) begin
                iaddr = clip(iaddr + c * istride);
                istride = clip(istride * dim_extent(idx_shape, ir, k));
                k--;
            end
        end
        if (iaddr >= INDEX_DEPTH) begin
            r.status = STATUS_INDEX_OVF;
            return r;
        end
        // Trailing source dimensions.
        rest = pos; saddr = 0; sstride = 1; k = xr - 1;
        for (j = yr - 1; j >= ax + ir; j--) begin
            e = out_ext(yr, j);
            c = rest % e;
            rest = rest / e;
            saddr = clip(saddr + c * sstride);
            sstride = clip(sstride * dim_extent(src_shape, xr, k));
            k--;
        end
        // Clamped index on the gathered axis.
        iw = idx_mem[iaddr];
        e = dim_extent(src_shape, xr, k);
        lim = (e == 0) ? 0 : e - 1;
        if (iw[31]) begin
            sel = 0;
        end else begin
            sel = (longint'(iw) > lim) ? lim : longint'(iw);
        end
        saddr = clip(saddr + sel * sstride);
        sstride = clip(sstride * e);
        k--;
        // Leading source dimensions.
        rest = pos;
        for (j = yr - 1; j >= 0 && k >= 0; j--) begin
            e = out_ext(yr, j);
            c = rest % e;
            rest = rest / e;
            if (j < ax) begin
                saddr = clip(saddr + c * sstride);
                sstride = clip(sstride * dim_extent(src_shape, xr, k));
                k--;
            end
        end
        if (saddr >= SOURCE_DEPTH) begin
            r.status = STATUS_SOURCE_OVF;
            return r;
        end
        r.value = src_mem[saddr];
        r.status = STATUS_OK;
        return r;
    endfunction

    assign pending = expected_q.size();

    initial begin
        mismatches = 0;
    end

    always @(posedge aclk) begin
        gather_result_t got, want;
        if (!aresetn) begin
            src_shape <= SHAPE_RESET;
            out_shape <= SHAPE_RESET;
            idx_shape <= SHAPE_RESET;
            src_rank  <= 3'd1;
            out_rank  <= 3'd1;
            idx_rank  <= 3'd0;
            axis_reg  <= 3'd0;
            out_count <= '0;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_SOURCE_SHAPE: src_shape <= cfg_data;
                    REG_OUTPUT_SHAPE: out_shape <= cfg_data;
                    REG_INDEX_SHAPE:  idx_shape <= cfg_data;
                    REG_SOURCE_RANK:  src_rank  <= cfg_data[2:0];
                    REG_OUTPUT_RANK:  out_rank  <= cfg_data[2:0];
                    REG_INDEX_RANK:   idx_rank  <= cfg_data[2:0];
                    REG_GATHER_AXIS:  axis_reg  <= cfg_data[2:0];
                    REG_OUTPUT_COUNT: out_count <= cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got.value = m_value;
                got.status = status_t'(m_status);
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: value %h status %0d", m_value, m_status);
                    end
                end else begin
                    want = expected_q.pop_front();
                    if (got.value !== want.value || got.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected value %h status %0d, got %h %0d",
                                     want.value, want.status, got.value, got.status);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                case (command_t'(s_command))
                    CMD_LOAD_SOURCE: src_mem[s_load_address] = s_load_value;
                    CMD_LOAD_INDEX: begin
                        if (s_load_address < INDEX_DEPTH) begin
                            idx_mem[s_load_address[IDX_AW-1:0]] = s_load_value;
                        end
                    end
                    CMD_GATHER: expected_q.push_back(gather_word(s_position));
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and gather transactions through the tensor take unit under a
// series of shape settings, with random gaps and stalls on both channels; a
// checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import ttg_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    // Drain time that covers a rank-6 gather and any straggler.
    localparam int DRAIN_CYCLES = 300;
    // Random phases keep every extent at three or below and every rank at four
    // or below, so a source address stays under 3^5 and an index address under
    // 3^4. Only those leading words are filled before the first gather.
    localparam int SRC_FILL = 243;
    localparam int IDX_FILL = 81;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [2:0]          cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_command = '0;
    logic [ADDR_W-1:0]   s_load_address = '0;
    logic signed [WORD_W-1:0] s_load_value = '0;
    logic [POS_W-1:0]    s_position = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic signed [WORD_W-1:0] m_value;
    logic [1:0]          m_status;
    int                  pending;
    int                  mismatches;
    int                  cycles = 0;

    // Set by the stimulus: no idling at all while high.
    bit                  no_gaps = 1'b0;
    // Set by the stimulus once; the receiver then stalls for a long stretch.
    bit                  long_stall = 1'b0;
    // Current output element count, used to aim positions inside the tensor.
    int                  target_count = 0;

    always #2 aclk = ~aclk;

    tensor_take_gather_unit i_dut (.*);

    ttg_checker i_checker (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** tensor_take_gather_unit: FAILED **");
            $finish;
        end
    end

    // Result side: random stalls per transaction and one long hold-off that
    // lets the unit fill up and push back on the command channel.
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_stall) begin
                m_ready = 1'b0;
                repeat (600) @(negedge aclk);
                long_stall = 1'b0;
            end
            stall = no_gaps ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Offers one command transaction and returns after it is taken.
    task automatic send_command(command_t cmd, logic [ADDR_W-1:0] addr,
                                logic [WORD_W-1:0] word, logic [POS_W-1:0] pos);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_command = cmd;
        s_load_address = addr;
        s_load_value = word;
        s_position = pos;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_register(cfg_reg_t idx, logic [CFG_W-1:0] data);
        s_valid = 1'b0;
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Waits for every result, then a full gather latency, before reconfiguring.
    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_shapes(logic [CFG_W-1:0] xs, logic [CFG_W-1:0] ys,
                              logic [CFG_W-1:0] is, logic [2:0] xr, logic [2:0] yr,
                              logic [2:0] ir, logic [2:0] ax, logic [CFG_W-1:0] cnt);
        wait_idle();
        write_register(REG_SOURCE_SHAPE, xs);
        write_register(REG_OUTPUT_SHAPE, ys);
        write_register(REG_INDEX_SHAPE, is);
        write_register(REG_SOURCE_RANK, CFG_W'(xr));
        write_register(REG_OUTPUT_RANK, CFG_W'(yr));
        write_register(REG_INDEX_RANK, CFG_W'(ir));
        write_register(REG_GATHER_AXIS, CFG_W'(ax));
        write_register(REG_OUTPUT_COUNT, cnt);
        target_count = int'(cnt[COUNT_W-1:0]);
    endtask

    // One random transaction; most are gathers aimed inside the output tensor.
    task automatic random_command();
        int pick;
        logic [POS_W-1:0] pos;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            if (target_count > 0 && $urandom_range(0, 9) < 8) begin
                pos = POS_W'($urandom_range(0, (target_count > (1 << POS_W)) ?
                                            (1 << POS_W) - 1 : target_count - 1));
            end else begin
                pos = POS_W'($urandom);
            end
            send_command(CMD_GATHER, ADDR_W'($urandom), $urandom, pos);
        end else if (pick < 88) begin
            send_command(CMD_LOAD_SOURCE, ADDR_W'($urandom), $urandom, POS_W'($urandom));
        end else if (pick < 98) begin
            send_command(CMD_LOAD_INDEX, ADDR_W'($urandom), $urandom, POS_W'($urandom));
        end else begin
            send_command(command_t'(2'd3), ADDR_W'($urandom), $urandom, POS_W'($urandom));
        end
    endtask

    initial begin
        logic [CFG_W-1:0] shp [3];
        logic [2:0]       rk [3];
        longint           count;
        int               ext;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Fill the part of both stores that any gather below can reach.
        no_gaps = 1'b1;
        for (int a = 0; a < SRC_FILL; a++) begin
            send_command(CMD_LOAD_SOURCE, ADDR_W'(a), $urandom, '0);
        end
        for (int a = 0; a < IDX_FILL; a++) begin
            send_command(CMD_LOAD_INDEX, ADDR_W'(a), $urandom, '0);
        end
        no_gaps = 1'b0;

        // Defaults after reset: no output element exists yet, so every gather
        // is out of range. Also an index load past the store and command 3.
        send_command(CMD_GATHER, '0, '0, '0);
        send_command(CMD_GATHER, '0, '0, '1);
        send_command(CMD_LOAD_INDEX, '1, 32'h7fff_ffff, '0);
        send_command(command_t'(2'd3), '1, '1, '1);

        // Largest extents, ranks beyond six, largest count. The index address
        // equals the position here, so positions from 1024 up overflow it.
        set_shapes('1, '1, '1, 3'd7, 3'd7, 3'd7, 3'd0, '1);
        for (int n = 0; n < 5; n++) begin
            send_command(CMD_GATHER, '0, '0,
                         (n == 0) ? '1 : POS_W'($urandom_range(1024, (1 << POS_W) - 1)));
        end

        // Same extents without an index span: the source address equals the
        // position, so positions from 4096 up overflow the source store.
        set_shapes('1, '1, '1, 3'd7, 3'd7, 3'd0, 3'd0, '1);
        for (int n = 0; n < 5; n++) begin
            send_command(CMD_GATHER, '0, '0,
                         (n == 0) ? '1 : (n == 1) ? POS_W'(100) :
                         POS_W'($urandom_range(4096, (1 << POS_W) - 1)));
        end

        // Zero extents everywhere: output dims divide as one, clamps go to 0.
        set_shapes('0, '0, '0, 3'd6, 3'd6, 3'd2, 3'd5, CFG_W'(1000));
        for (int n = 0; n < 5; n++) begin
            send_command(CMD_GATHER, '0, '0, (n == 0) ? POS_W'(999) : POS_W'(1000 + n));
        end

        // Small one-dimensional take: negative and oversized indices clamp.
        set_shapes(60'd8, 60'd4, 60'd4, 3'd1, 3'd1, 3'd1, 3'd0, CFG_W'(4));
        send_command(CMD_LOAD_INDEX, 12'd0, 32'h8000_0000, '0);
        send_command(CMD_LOAD_INDEX, 12'd1, 32'h7fff_ffff, '0);
        send_command(CMD_LOAD_INDEX, 12'd2, 32'd7, '0);
        send_command(CMD_LOAD_INDEX, 12'd3, 32'd3, '0);
        for (int n = 0; n < 5; n++) begin
            send_command(CMD_GATHER, '0, '0, POS_W'(n));
        end

        // Random phases; the first stretch runs without idling and the
        // second carries the long receiver hold-off.
        for (int ph = 0; ph < 8; ph++) begin
            for (int t = 0; t < 3; t++) begin
                shp[t] = '0;
                for (int s = 0; s < MAX_RANK; s++) begin
                    ext = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
                    shp[t][EXTENT_BITS*s +: EXTENT_BITS] = EXTENT_BITS'(ext);
                end
                rk[t] = (t == 0) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 4));
            end
            count = 1;
            for (int s = MAX_RANK - ((rk[1] > MAX_RANK) ? MAX_RANK : rk[1]); s < MAX_RANK; s++) begin
                ext = shp[1][EXTENT_BITS*s +: EXTENT_BITS];
                count = count * ((ext == 0) ? 1 : ext);
            end
            count = count + $urandom_range(0, 3);
            if (count > (1 << COUNT_W) - 1) begin
                count = (1 << COUNT_W) - 1;
            end
            set_shapes(shp[0], shp[1], shp[2], rk[0], rk[1], rk[2],
                       3'($urandom_range(0, 7)), CFG_W'(count));
            no_gaps = (ph == 0);
            if (ph == 1) begin
                long_stall = 1'b1;
            end
            for (int n = 0; n < 170; n++) begin
                random_command();
            end
        end
        no_gaps = 1'b0;

        wait_idle();
        if (mismatches == 0) begin
            $display("** tensor_take_gather_unit: PASSED **");
        end else begin
            $display("** tensor_take_gather_unit: FAILED **");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/ttg_pkg.sv
sv/ttg_div.sv
sv/ttg_dpath.sv
sv/ttg_ctrl.sv
sv/tensor_take_gather_unit.sv
tb/ttg_checker.sv
tb/testbench.sv
